// ===== rtl/open_address_hash_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the open-address hash table
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OAHT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OAHT_ASSERT(label, clk, rst_n, prop, msg)
`define OAHT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// Open-address hash table package
// Command and status codes, config register indices, key width, sequencer state type.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [3:0] ST_INSERTED    = 4'd0;
    localparam logic [3:0] ST_EXISTS      = 4'd1;
    localparam logic [3:0] ST_FOUND       = 4'd2;
    localparam logic [3:0] ST_NOT_FOUND   = 4'd3;
    localparam logic [3:0] ST_DELETED     = 4'd4;
    localparam logic [3:0] ST_DEL_MISSING = 4'd5;
    localparam logic [3:0] ST_FULL        = 4'd6;
    localparam logic [3:0] ST_INVALID     = 4'd7;
    localparam logic [3:0] ST_READ        = 4'd8;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    localparam int KEY_W = 31;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_ADDR  = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/oaht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/open_address_hash_table.sv =====
// ----------------------------------------------------------------------------
// Open-address hash table
// Linear or quadratic probing over a single-port slot memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to empty, one slot a cycle,
// before it takes a command. Each command then runs one at a time: the
// home slot is found by a restoring remainder unit, one quotient bit a
// cycle, and the probe walk takes each slot visited through the one memory
// port in the steps address, read and compare. An insert that misses walks
// the path twice: once to search, once to place. A read-slot command inside
// the table passes through S_WAIT, S_CHECK and S_OUT before its result is
// registered; an invalid key or a read beyond the table size goes straight
// to S_OUT. The result sits in an output register until taken; the input is
// stalled meanwhile.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_command,
    input  logic [oaht_pkg::KEY_W-1:0]    i_key,
    input  logic [7:0]                    i_slot_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [3:0]                    o_status,
    output logic [7:0]                    o_slot,
    output logic [oaht_pkg::KEY_W-1:0]    o_slot_key,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [0:0]                    i_cfg_index,
    input  logic [8:0]                    i_cfg_data
);
`include "open_address_hash_table_macros.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = oaht_pkg::KEY_W;
    localparam int DW = (SW > 9) ? SW : 9;

    oaht_pkg::t_state r_state, n_state;

    logic          r_mode;
    logic [8:0]    r_size_reg;
    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [7:0]    r_idx;
    logic [SW-1:0] r_size;
    logic [SW:0]   r_rem;
    logic [4:0]    r_bit;
    logic [AW-1:0] r_home;
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_step;
    logic [SW:0]   r_odd;
    logic          r_place;
    logic [AW-1:0] r_addr;
    logic          r_valid;
    logic [3:0]    r_status;
    logic [7:0]    r_slot;
    logic [KW-1:0] r_skey;

    logic          we;
    logic [AW-1:0] ram_addr;
    logic [KW-1:0] wdata;
    logic [KW-1:0] rdata;

    // effective size: zero means one, clip to depth
    logic [DW-1:0] size_ext;
    logic [SW-1:0] eff_size;
    always_comb begin
        size_ext = DW'(r_size_reg);
        if (size_ext == '0) begin
            eff_size = SW'(1);
        end else if (size_ext > DW'(TABLE_DEPTH)) begin
            eff_size = SW'(TABLE_DEPTH);
        end else begin
            eff_size = SW'(size_ext);
        end
    end

    // remainder step, one key bit shifted in
    logic [SW:0] rem_sh;
    logic [SW:0] rem_nx;
    always_comb begin
        rem_sh = {r_rem[SW-1:0], r_key[r_bit]};
        rem_nx = (rem_sh >= {1'b0, r_size}) ? rem_sh - {1'b0, r_size} : rem_sh;
    end

    // probe address: home plus step, modulo size
    logic [SW:0] paddr;
    always_comb begin
        paddr = {1'b0, SW'(r_home)} + {1'b0, r_step};
        if (paddr >= {1'b0, r_size}) begin
            paddr = paddr - {1'b0, r_size};
        end
    end

    // next step: i+1 or (i+1)^2 by adding successive odd numbers, mod size
    logic [SW+1:0] step_nx;
    logic [SW:0]   odd_nx;
    always_comb begin
        if (r_mode) begin
            step_nx = {2'b0, r_step} + {1'b0, r_odd};
            odd_nx  = r_odd + (SW+1)'(2);
        end else begin
            step_nx = {2'b0, r_step} + (SW+2)'(1);
            odd_nx  = r_odd;
        end
        if (step_nx >= {2'b0, r_size}) begin
            step_nx = step_nx - {2'b0, r_size};
        end
        if (step_nx >= {2'b0, r_size}) begin
            step_nx = step_nx - {2'b0, r_size};
        end
        if (odd_nx >= {1'b0, r_size}) begin
            odd_nx = odd_nx - {1'b0, r_size};
        end
    end

    logic last_probe;
    assign last_probe = (r_i == r_size - SW'(1));

    assign o_stall     = (r_state != oaht_pkg::S_IDLE) || r_valid;
    assign o_cfg_ready = (r_state == oaht_pkg::S_IDLE) && !r_valid;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_slot_key  = r_skey;

    // memory port control
    always_comb begin
        we       = 1'b0;
        ram_addr = r_addr;
        wdata    = '0;
        case (r_state)
            oaht_pkg::S_CLEAR: begin
                we = 1'b1;
            end
            oaht_pkg::S_WRITE: begin
                we    = 1'b1;
                wdata = (r_cmd == oaht_pkg::CMD_INSERT) ? r_key : '0;
            end
            default: begin
            end
        endcase
    end

    oaht_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (ram_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            oaht_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    if (i_command == oaht_pkg::CMD_READ) begin
                        n_state = ({1'b0, i_slot_index} < DW'(eff_size)) ?
                                  oaht_pkg::S_WAIT : oaht_pkg::S_OUT;
                    end else if (i_key == '0) begin
                        n_state = oaht_pkg::S_OUT;
                    end else begin
                        n_state = oaht_pkg::S_MOD;
                    end
                end
            end
            oaht_pkg::S_CLEAR: begin
                if (r_addr == AW'(TABLE_DEPTH - 1)) n_state = oaht_pkg::S_IDLE;
            end
            oaht_pkg::S_MOD:   if (r_bit == '0) n_state = oaht_pkg::S_ADDR;
            oaht_pkg::S_ADDR:  n_state = oaht_pkg::S_WAIT;
            oaht_pkg::S_WAIT:  n_state = oaht_pkg::S_CHECK;
            oaht_pkg::S_CHECK: begin
                if (r_cmd == oaht_pkg::CMD_READ) begin
                    n_state = oaht_pkg::S_OUT;
                end else if (r_place) begin
                    if (rdata == '0) n_state = oaht_pkg::S_WRITE;
                    else if (last_probe) n_state = oaht_pkg::S_OUT;
                    else n_state = oaht_pkg::S_ADDR;
                end else if (rdata == r_key) begin
                    n_state = (r_cmd == oaht_pkg::CMD_DELETE) ?
                              oaht_pkg::S_WRITE : oaht_pkg::S_OUT;
                end else if (rdata == '0 || last_probe) begin
                    n_state = (r_cmd == oaht_pkg::CMD_INSERT) ?
                              oaht_pkg::S_ADDR : oaht_pkg::S_OUT;
                end else begin
                    n_state = oaht_pkg::S_ADDR;
                end
            end
            oaht_pkg::S_WRITE: n_state = oaht_pkg::S_OUT;
            oaht_pkg::S_OUT:   n_state = oaht_pkg::S_IDLE;
            default:           n_state = oaht_pkg::S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= oaht_pkg::S_CLEAR;
            r_addr     <= '0;
            r_valid    <= 1'b0;
            r_mode     <= 1'b0;
            r_size_reg <= 9'd256;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == oaht_pkg::REG_MODE) r_mode <= i_cfg_data[0];
                else r_size_reg <= i_cfg_data;
            end
            case (r_state)
                oaht_pkg::S_CLEAR: r_addr <= r_addr + AW'(1);
                oaht_pkg::S_IDLE: begin
                    if (i_valid && !o_stall) r_addr <= AW'(i_slot_index);
                end
                oaht_pkg::S_ADDR: r_addr <= AW'(paddr);
                oaht_pkg::S_OUT:  r_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            oaht_pkg::S_IDLE: begin
                // load a new beat only when it is accepted; hold a waiting result
                if (i_valid && !o_stall) begin
                    r_cmd   <= i_command;
                    r_key   <= i_key;
                    r_idx   <= i_slot_index;
                    r_size  <= eff_size;
                    r_rem   <= '0;
                    r_bit   <= 5'(KW - 1);
                    r_i     <= '0;
                    r_step  <= '0;
                    r_odd   <= (SW+1)'(1);
                    r_place <= 1'b0;
                    r_slot  <= '0;
                    if (i_command == oaht_pkg::CMD_READ) begin
                        r_status <= oaht_pkg::ST_READ;
                        r_slot   <= i_slot_index;
                        r_skey   <= '0;
                    end else if (i_key == '0) begin
                        r_status <= oaht_pkg::ST_INVALID;
                        r_skey   <= '0;
                    end else begin
                        r_skey <= i_key;
                        case (i_command)
                            oaht_pkg::CMD_INSERT: r_status <= oaht_pkg::ST_FULL;
                            oaht_pkg::CMD_FIND:   r_status <= oaht_pkg::ST_NOT_FOUND;
                            default:              r_status <= oaht_pkg::ST_DEL_MISSING;
                        endcase
                    end
                end
            end
            oaht_pkg::S_MOD: begin
                r_rem <= rem_nx;
                r_bit <= r_bit - 5'd1;
                if (r_bit == '0) r_home <= AW'(rem_nx);
            end
            oaht_pkg::S_CHECK: begin
                r_i    <= r_i + SW'(1);
                r_step <= SW'(step_nx);
                r_odd  <= odd_nx;
                if (r_cmd == oaht_pkg::CMD_READ) begin
                    r_skey <= rdata;
                end else if (r_place) begin
                    if (rdata == '0) begin
                        r_status <= oaht_pkg::ST_INSERTED;
                        r_slot   <= 8'(r_addr);
                    end
                end else if (rdata == r_key) begin
                    r_slot <= 8'(r_addr);
                    case (r_cmd)
                        oaht_pkg::CMD_INSERT: r_status <= oaht_pkg::ST_EXISTS;
                        oaht_pkg::CMD_FIND:   r_status <= oaht_pkg::ST_FOUND;
                        default:              r_status <= oaht_pkg::ST_DELETED;
                    endcase
                end else if ((rdata == '0 || last_probe) &&
                             r_cmd == oaht_pkg::CMD_INSERT) begin
                    // restart the walk to place the key
                    r_place <= 1'b1;
                    r_i     <= '0;
                    r_step  <= '0;
                    r_odd   <= (SW+1)'(1);
                end
            end
            default: begin
            end
        endcase
    end

    logic unused_idx;
    assign unused_idx = ^r_idx;

    `OAHT_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != oaht_pkg::S_IDLE) |-> o_stall, "accept while busy")
    `OAHT_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(r_valid) |-> $past(r_state == oaht_pkg::S_OUT), "result without sequencer")
    `OAHT_ASSERT(a_home_in_range, i_clk, i_rst_n, (r_state == oaht_pkg::S_ADDR) |-> ({1'b0, SW'(r_home)} < {1'b0, r_size}), "home out of range")
    `OAHT_ASSERT(a_write_nonread, i_clk, i_rst_n, (r_state == oaht_pkg::S_WRITE) |-> (r_cmd != oaht_pkg::CMD_READ), "write on read")

endmodule
